[hdl/vgoi_pkg.sv]
// ============================================================================
// vgoi_pkg
// Shared types, widths and helpers for the frame-level gamma offset
// interpolator.
// ============================================================================
package vgoi_pkg;

    localparam int LEVELS_DEF   = 8;
    localparam int ENTRIES_DEF  = 256;
    localparam int CHANNELS_DEF = 3;

    localparam int SAMPLE_W   = 12;
    localparam int VALUE_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int CHAN_W     = 2;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 8;
    localparam int FRAC_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_CORRECT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_HW  = 2'd0,
        CFG_LEVEL_SW  = 2'd1,
        CFG_LEVEL_SEL = 2'd2,
        CFG_ZERO_OFS  = 2'd3
    } cfg_idx_t;

    // divide by 16, half rounds away from zero
    function automatic logic signed [22:0] div16_rnd(input logic signed [22:0] x);
        logic signed [23:0] mag;
        logic signed [23:0] quo;
        mag = x[22] ? -24'(x) : 24'(x);
        quo = (mag + 24'sd8) >>> 4;
        return x[22] ? 23'(-quo) : 23'(quo);
    endfunction

endpackage

[hdl/vrr_gamma_offset_interp_top.sv]
// ============================================================================
// vrr_gamma_offset_interp_top
// Per-channel gamma offset correction of 12-bit subpixels, bilinear in gray
// level and frame level over a loadable offset table.
// ============================================================================
// Six-stage pipeline taking one item per clock while item_stall is low; a
// sample's result is registered through every stage and held until taken. The
// table sits in four banks split by row and column parity, so the four
// neighbor entries of a sample are read in the single memory cycle of
// stage one. Table writes go through the same memory stage in item order, so a
// sample sees every write transferred before it. Stall on the input rises only
// when the output register holds an untaken result and every stage is full.
module vrr_gamma_offset_interp_top #(
    parameter int LEVELS   = vgoi_pkg::LEVELS_DEF,
    parameter int ENTRIES  = vgoi_pkg::ENTRIES_DEF,
    parameter int CHANNELS = vgoi_pkg::CHANNELS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [vgoi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vgoi_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic                                   action,
    input  logic [vgoi_pkg::CHAN_W-1:0]            channel,
    input  logic [vgoi_pkg::ROW_W-1:0]             table_row,
    input  logic [vgoi_pkg::COL_W-1:0]             table_column,
    input  logic signed [vgoi_pkg::VALUE_W-1:0]    table_value,
    input  logic [vgoi_pkg::SAMPLE_W-1:0]          sample,

    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [vgoi_pkg::SAMPLE_W-1:0]          corrected,
    output logic [vgoi_pkg::CHAN_W-1:0]            out_channel
);

    localparam int LW    = $clog2(LEVELS);
    localparam int LW1   = LW + 1;
    localparam int RHW   = (LW > 1) ? LW - 1 : 1;
    localparam int EW    = $clog2(ENTRIES);
    localparam int EW1   = EW + 1;
    localparam int CHW   = EW - 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW    = CW + RHW + CHW;
    localparam int DEPTH = 1 << AW;
    localparam int VW    = vgoi_pkg::VALUE_W;
    localparam int SW    = vgoi_pkg::SAMPLE_W;
    localparam int FW    = vgoi_pkg::FRAC_W;
    localparam int NW    = vgoi_pkg::CHAN_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [vgoi_pkg::LEVEL_W-1:0] level_hw_reg;
    logic [vgoi_pkg::LEVEL_W-1:0] level_sw_reg;
    logic                         level_sel_reg;
    logic signed [VW-1:0]         zero_ofs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_hw_reg  <= '0;
            level_sw_reg  <= '0;
            level_sel_reg <= 1'b0;
            zero_ofs_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (vgoi_pkg::cfg_idx_t'(cfg_index))
                vgoi_pkg::CFG_LEVEL_HW:  level_hw_reg  <= cfg_data[vgoi_pkg::LEVEL_W-1:0];
                vgoi_pkg::CFG_LEVEL_SW:  level_sw_reg  <= cfg_data[vgoi_pkg::LEVEL_W-1:0];
                vgoi_pkg::CFG_LEVEL_SEL: level_sel_reg <= cfg_data[0];
                vgoi_pkg::CFG_ZERO_OFS:  zero_ofs_reg  <= signed'(cfg_data[VW-1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;
    logic in_xfer;

    assign en6        = !v6_reg || !result_stall;
    assign en5        = !v5_reg || en6;
    assign en4        = !v4_reg || en5;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign item_stall = !en1;
    assign in_xfer    = item_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_xfer && (action == vgoi_pkg::ACT_CORRECT);
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: address decode, table banks
    // ------------------------------------------------------------------
    logic [vgoi_pkg::LEVEL_W-1:0] level;
    logic [3:0]                   level_hi;
    logic [LW-1:0]                r0;
    logic [LW1-1:0]               r0p1;
    logic [RHW-1:0]               rh0, rh1;
    logic [EW-1:0]                c0;
    logic [EW1-1:0]               c0p1;
    logic [CHW-1:0]               ch0, ch1;
    logic [CW-1:0]                tc;
    logic                         rclamp, cclamp;

    assign level    = level_sel_reg ? level_sw_reg : level_hw_reg;
    assign level_hi = level[7:4];
    assign r0       = (5'(level_hi) > 5'(LEVELS - 1)) ? LW'(LEVELS - 1) : LW'(level_hi);
    assign r0p1     = LW1'(r0) + LW1'(1);
    assign rh0      = RHW'(r0 >> 1);
    assign rh1      = RHW'(r0p1 >> 1);
    assign rclamp   = (r0 == LW'(LEVELS - 1));
    assign c0       = (9'(sample[SW-1:FW]) > 9'(ENTRIES - 1)) ?
                      EW'(ENTRIES - 1) : EW'(sample[SW-1:FW]);
    assign c0p1     = EW1'(c0) + EW1'(1);
    assign ch0      = CHW'(c0 >> 1);
    assign ch1      = CHW'(c0p1 >> 1);
    assign cclamp   = (c0 == EW'(ENTRIES - 1));
    assign tc       = (3'(channel) >= 3'(CHANNELS)) ? CW'(CHANNELS - 1) : CW'(channel);

    logic          wr_ok;
    logic [LW-1:0] wrow;
    logic [EW-1:0] wcol;
    logic [AW-1:0] waddr;

    assign wr_ok = in_xfer && (action == vgoi_pkg::ACT_WRITE)
                   && (3'(channel) < 3'(CHANNELS))
                   && (5'(table_row) < 5'(LEVELS))
                   && (9'(table_column) < 9'(ENTRIES));
    assign wrow  = LW'(table_row);
    assign wcol  = EW'(table_column);
    assign waddr = {CW'(channel), RHW'(wrow >> 1), CHW'(wcol >> 1)};

    logic [VW-1:0] rd_reg [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BP = 1'((b >> 1) & 1);
        localparam logic BQ = 1'(b & 1);

        logic [VW-1:0] mem [DEPTH];
        logic [AW-1:0] raddr;

        assign raddr = {tc, (BP == r0[0]) ? rh0 : rh1, (BQ == c0[0]) ? ch0 : ch1};

        always_ff @(posedge clk)
        begin
            if (wr_ok && (table_row[0] == BP) && (table_column[0] == BQ))
                mem[waddr] <= table_value;
            if (en1)
                rd_reg[b] <= mem[raddr];
        end
    end

    logic [SW-1:0] sample1_reg;
    logic [NW-1:0] chan1_reg;
    logic [FW-1:0] w1_reg;
    logic          rpar1_reg, cpar1_reg, rcl1_reg, ccl1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sample1_reg <= sample;
            chan1_reg   <= channel;
            w1_reg      <= level[FW-1:0];
            rpar1_reg   <= r0[0];
            cpar1_reg   <= c0[0];
            rcl1_reg    <= rclamp;
            ccl1_reg    <= cclamp;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: gray interpolation products
    // ------------------------------------------------------------------
    logic signed [VW-1:0] t00, t01, t10, t11;
    logic signed [VW-1:0] a0, b0, a1, b1;
    logic [4:0]           finv;
    logic signed [5:0]    fa_s, fb_s;
    logic signed [22:0]   p0_next, p1_next;

    // T[row][col] relative to r0/c0 from the parity banks
    assign t00 = signed'(rpar1_reg ? (cpar1_reg ? rd_reg[3] : rd_reg[2])
                                   : (cpar1_reg ? rd_reg[1] : rd_reg[0]));
    assign t01 = signed'(rpar1_reg ? (cpar1_reg ? rd_reg[2] : rd_reg[3])
                                   : (cpar1_reg ? rd_reg[0] : rd_reg[1]));
    assign t10 = signed'(rpar1_reg ? (cpar1_reg ? rd_reg[1] : rd_reg[0])
                                   : (cpar1_reg ? rd_reg[3] : rd_reg[2]));
    assign t11 = signed'(rpar1_reg ? (cpar1_reg ? rd_reg[0] : rd_reg[1])
                                   : (cpar1_reg ? rd_reg[2] : rd_reg[3]));

    // clamped neighbors repeat the base entry
    assign a0 = t00;
    assign b0 = ccl1_reg ? t00 : t01;
    assign a1 = rcl1_reg ? a0 : t10;
    assign b1 = rcl1_reg ? b0 : (ccl1_reg ? t10 : t11);

    assign finv    = 5'd16 - 5'(sample1_reg[FW-1:0]);
    assign fa_s    = signed'({1'b0, finv});
    assign fb_s    = signed'({2'b0, sample1_reg[FW-1:0]});
    assign p0_next = 23'(a0) * 23'(fa_s) + 23'(b0) * 23'(fb_s);
    assign p1_next = 23'(a1) * 23'(fa_s) + 23'(b1) * 23'(fb_s);

    logic signed [22:0] p0_reg, p1_reg;
    logic [SW-1:0]      sample2_reg;
    logic [NW-1:0]      chan2_reg;
    logic [FW-1:0]      w2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            sample2_reg <= sample1_reg;
            chan2_reg   <= chan1_reg;
            w2_reg      <= w1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: row values
    // ------------------------------------------------------------------
    logic signed [16:0] r0v_reg, r1v_reg;
    logic [SW-1:0]      sample3_reg;
    logic [NW-1:0]      chan3_reg;
    logic [FW-1:0]      w3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            r0v_reg     <= 17'(vgoi_pkg::div16_rnd(p0_reg));
            r1v_reg     <= 17'(vgoi_pkg::div16_rnd(p1_reg));
            sample3_reg <= sample2_reg;
            chan3_reg   <= chan2_reg;
            w3_reg      <= w2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: frame level blend products
    // ------------------------------------------------------------------
    logic [4:0]         winv;
    logic signed [5:0]  wa_s, wb_s;
    logic signed [22:0] q_next;

    assign winv   = 5'd16 - 5'(w3_reg);
    assign wa_s   = signed'({1'b0, winv});
    assign wb_s   = signed'({2'b0, w3_reg});
    assign q_next = 23'(r0v_reg) * 23'(wa_s) + 23'(r1v_reg) * 23'(wb_s);

    logic signed [22:0] q_reg;
    logic [SW-1:0]      sample4_reg;
    logic [NW-1:0]      chan4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            q_reg       <= q_next;
            sample4_reg <= sample3_reg;
            chan4_reg   <= chan3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: offset
    // ------------------------------------------------------------------
    logic signed [17:0] ofs_next;

    assign ofs_next = 18'(vgoi_pkg::div16_rnd(q_reg)) - 18'(zero_ofs_reg);

    logic signed [17:0] ofs5_reg;
    logic [SW-1:0]      sample5_reg;
    logic [NW-1:0]      chan5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ofs5_reg    <= ofs_next;
            sample5_reg <= sample4_reg;
            chan5_reg   <= chan4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: add, clip, output register
    // ------------------------------------------------------------------
    logic signed [18:0] sum;
    logic [SW-1:0]      corrected_next;

    assign sum = 19'(ofs5_reg) + 19'(signed'({1'b0, sample5_reg}));

    always_comb
    begin
        if (sum < 19'sd0)
            corrected_next = '0;
        else if (sum > 19'(signed'({1'b0, vgoi_pkg::SAMPLE_MAX})))
            corrected_next = vgoi_pkg::SAMPLE_MAX;
        else
            corrected_next = sum[SW-1:0];
    end

    logic [SW-1:0] corrected_reg;
    logic [NW-1:0] chan6_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            corrected_reg <= corrected_next;
            chan6_reg     <= chan5_reg;
        end
    end

    assign result_valid = v6_reg;
    assign corrected    = corrected_reg;
    assign out_channel  = chan6_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg
                        && result_stall))
        else $error("input stalled with room in the pipeline");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (action == vgoi_pkg::ACT_WRITE)) |=> !v1_reg)
        else $error("table write entered the result path");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (action == vgoi_pkg::ACT_CORRECT)) |=> v1_reg)
        else $error("sample transfer lost at stage one");

    a_out_moves_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && !result_stall && !v5_reg) |=> !v6_reg)
        else $error("result repeated after transfer");
`endif

endmodule
